@@ hdl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the speech segment tracker.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int CNT_W  = 32;
	localparam int PROB_W = 16;
	localparam int WIN_W  = 16;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_SPEECH_THRESHOLD = 3'd0,
		REG_HYSTERESIS_GAP   = 3'd1,
		REG_WINDOW_SAMPLES   = 3'd2,
		REG_MIN_SILENCE      = 3'd3,
		REG_PAUSE_MARK       = 3'd4,
		REG_MIN_SPEECH       = 3'd5,
		REG_MAX_SPEECH       = 3'd6
	} reg_idx_t;

	typedef enum logic {
		REQ_WINDOW = 1'b0,
		REQ_END    = 1'b1
	} req_t;

	typedef struct packed {
		logic [PROB_W-1:0] speech_threshold;
		logic [PROB_W-1:0] hysteresis_gap;
		logic [WIN_W-1:0]  window_samples;
		logic [CNT_W-1:0]  silence_close_len;
		logic [CNT_W-1:0]  pause_mark_samples;
		logic [CNT_W-1:0]  seg_min_len;
		logic [CNT_W-1:0]  seg_max_len;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] seg_start;
		logic [CNT_W-1:0] seg_end;
	} seg_t;

	localparam logic [PROB_W-1:0] RST_THRESHOLD   = 16'd32768;
	localparam logic [PROB_W-1:0] RST_GAP         = 16'd9830;
	localparam logic [WIN_W-1:0]  RST_WINDOW      = 16'd1024;
	localparam logic [CNT_W-1:0]  RST_MIN_SILENCE = 32'd0;
	localparam logic [CNT_W-1:0]  RST_PAUSE_MARK  = 32'd1568;
	localparam logic [CNT_W-1:0]  RST_MIN_SPEECH  = 32'd1024;
	localparam logic [CNT_W-1:0]  NEVER_LIMIT     = '1;

endpackage

@@ hdl/sst_cfg.sv @@
// ----------------------------------------------------------------------------
// sst_cfg
// Configuration register file, written one word per handshake.
// ----------------------------------------------------------------------------
module sst_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [sst_pkg::IDX_W-1:0]  wr_index,
	input  logic [sst_pkg::DATA_W-1:0] wr_data,
	output sst_pkg::cfg_t              cfg
);

	sst_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speech_threshold   <= sst_pkg::RST_THRESHOLD;
			cfg_q.hysteresis_gap     <= sst_pkg::RST_GAP;
			cfg_q.window_samples     <= sst_pkg::RST_WINDOW;
			cfg_q.silence_close_len  <= sst_pkg::RST_MIN_SILENCE;
			cfg_q.pause_mark_samples <= sst_pkg::RST_PAUSE_MARK;
			cfg_q.seg_min_len        <= sst_pkg::RST_MIN_SPEECH;
			cfg_q.seg_max_len        <= sst_pkg::NEVER_LIMIT;
		end else if (wr_en) begin
			unique case (sst_pkg::reg_idx_t'(wr_index))
				sst_pkg::REG_SPEECH_THRESHOLD: begin
					cfg_q.speech_threshold <= wr_data[sst_pkg::PROB_W-1:0];
				end
				sst_pkg::REG_HYSTERESIS_GAP: begin
					cfg_q.hysteresis_gap <= wr_data[sst_pkg::PROB_W-1:0];
				end
				sst_pkg::REG_WINDOW_SAMPLES: begin
					cfg_q.window_samples <= wr_data[sst_pkg::WIN_W-1:0];
				end
				sst_pkg::REG_MIN_SILENCE: begin
					cfg_q.silence_close_len <= wr_data[sst_pkg::CNT_W-1:0];
				end
				sst_pkg::REG_PAUSE_MARK: begin
					cfg_q.pause_mark_samples <= wr_data[sst_pkg::CNT_W-1:0];
				end
				sst_pkg::REG_MIN_SPEECH: begin
					cfg_q.seg_min_len <= wr_data[sst_pkg::CNT_W-1:0];
				end
				sst_pkg::REG_MAX_SPEECH: begin
					cfg_q.seg_max_len <= wr_data[sst_pkg::CNT_W-1:0];
				end
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/sst_core.sv @@
// ----------------------------------------------------------------------------
// sst_core
// Segment tracking state, the per-window enter, silence and split rules, and the end-of-audio flush.
// ----------------------------------------------------------------------------
module sst_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sst_pkg::cfg_t              cfg,
	input  logic                       accept,
	input  logic                       req_type,
	input  logic [sst_pkg::PROB_W-1:0] win_prob,
	input  logic [sst_pkg::CNT_W-1:0]  audio_length,
	output logic                       res_valid,
	output sst_pkg::seg_t              res
);

	localparam int CW = sst_pkg::CNT_W;
	localparam int PW = sst_pkg::PROB_W;

	logic          speaking_q, open_q;
	logic [CW-1:0] open_start_q, sample_pos_q, silence_begin_q, pause_end_q, resume_q;

	logic          speaking_d, open_d;
	logic [CW-1:0] open_start_d, sample_pos_d, silence_begin_d, pause_end_d, resume_d;

	logic [CW-1:0] win, pos_n, win_start, sb_eff, sil;
	logic [PW:0]   prob_plus_gap;
	logic          is_speech, is_neutral, over_limit;

	assign win           = CW'(cfg.window_samples);
	assign pos_n         = sample_pos_q + win;
	assign win_start     = pos_n - win;
	assign is_speech     = win_prob >= cfg.speech_threshold;
	assign prob_plus_gap = {1'b0, win_prob} + {1'b0, cfg.hysteresis_gap};
	assign is_neutral    = prob_plus_gap >= {1'b0, cfg.speech_threshold};
	assign over_limit    = speaking_q && (cfg.seg_max_len != sst_pkg::NEVER_LIMIT)
	                       && ((pos_n - open_start_q) > cfg.seg_max_len);
	assign sb_eff        = (silence_begin_q == '0) ? pos_n : silence_begin_q;
	assign sil           = pos_n - sb_eff;

	always_comb begin
		speaking_d      = speaking_q;
		open_d          = open_q;
		open_start_d    = open_start_q;
		sample_pos_d    = sample_pos_q;
		silence_begin_d = silence_begin_q;
		pause_end_d     = pause_end_q;
		resume_d        = resume_q;
		res_valid       = 1'b0;
		res.seg_start   = open_start_q;
		res.seg_end     = audio_length;

		if (sst_pkg::req_t'(req_type) == sst_pkg::REQ_END) begin
			res_valid       = open_q;
			speaking_d      = 1'b0;
			open_d          = 1'b0;
			open_start_d    = '0;
			sample_pos_d    = '0;
			silence_begin_d = '0;
			pause_end_d     = '0;
			resume_d        = '0;
		end else begin
			sample_pos_d = pos_n;
			if (is_speech) begin
				if (silence_begin_q != '0) begin
					silence_begin_d = '0;
					if (resume_q < pause_end_q) begin
						resume_d = win_start;
					end
				end
				if (!speaking_q) begin
					speaking_d   = 1'b1;
					open_d       = 1'b1;
					open_start_d = win_start;
				end
			end else if (over_limit) begin
				// split at the last pause, or at the current position if none
				res_valid = 1'b1;
				if (pause_end_q != '0) begin
					res.seg_end = pause_end_q;
					if (resume_q < pause_end_q) begin
						speaking_d   = 1'b0;
						open_d       = 1'b0;
						open_start_d = '0;
					end else begin
						open_start_d = resume_q;
						open_d       = 1'b1;
					end
				end else begin
					res.seg_end  = pos_n;
					speaking_d   = 1'b0;
					open_d       = 1'b0;
					open_start_d = '0;
				end
				pause_end_d     = '0;
				resume_d        = '0;
				silence_begin_d = '0;
			end else if (!is_neutral && speaking_q) begin
				silence_begin_d = sb_eff;
				if (sil > cfg.pause_mark_samples) begin
					pause_end_d = sb_eff;
				end
				if ((sil >= cfg.silence_close_len)
				    && ((sb_eff - open_start_q) > cfg.seg_min_len)) begin
					res_valid       = 1'b1;
					res.seg_end     = sb_eff;
					speaking_d      = 1'b0;
					open_d          = 1'b0;
					open_start_d    = '0;
					pause_end_d     = '0;
					resume_d        = '0;
					silence_begin_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speaking_q      <= 1'b0;
			open_q          <= 1'b0;
			open_start_q    <= '0;
			sample_pos_q    <= '0;
			silence_begin_q <= '0;
			pause_end_q     <= '0;
			resume_q        <= '0;
		end else if (accept) begin
			speaking_q      <= speaking_d;
			open_q          <= open_d;
			open_start_q    <= open_start_d;
			sample_pos_q    <= sample_pos_d;
			silence_begin_q <= silence_begin_d;
			pause_end_q     <= pause_end_d;
			resume_q        <= resume_d;
		end
	end

	// a segment is open exactly while speech is tracked
	a_open_tracks_speaking: assert property (@(posedge clk) disable iff (!arst_n)
		speaking_q == open_q)
		else $error("segment_open and speaking disagree");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type) |=> (sample_pos_q == '0 && !open_q && pause_end_q == '0))
		else $error("end of audio did not clear state");

	a_pause_needs_speech: assert property (@(posedge clk) disable iff (!arst_n)
		(silence_begin_q != '0) |-> speaking_q)
		else $error("silence tracked with no open segment");

endmodule

@@ hdl/sst_outq.sv @@
// ----------------------------------------------------------------------------
// sst_outq
// Result register with a skid entry so one more result is taken under output stall.
// ----------------------------------------------------------------------------
module sst_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sst_pkg::seg_t push_data,
	output logic          full,
	output logic          out_valid,
	output sst_pkg::seg_t out_data,
	input  logic          out_stall
);

	logic          main_v_q, skid_v_q;
	sst_pkg::seg_t main_q, skid_q;
	logic          pop;

	assign pop = main_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !main_v_q) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_v_q) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry held with empty result register");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && out_stall) |=> (skid_v_q && $stable(skid_q)))
		else $error("skid entry lost while output stalled");

endmodule

@@ hdl/speech_segment_tracker.sv @@
// ----------------------------------------------------------------------------
// speech_segment_tracker
// Voice activity segmentation with hysteresis over per-window probabilities.
// ----------------------------------------------------------------------------
// A segment closed by an accepted item is registered in the result register or its skid entry.
// Throughput: one item per cycle while in_stall is low; the rule logic is a single registered pass.
// in_stall rises only when both the result register and its skid entry are full.
// Reset clears all tracking state and sets the registers to their defaults;
// cfg_ready is always high, so a configuration write is never held off.
// ----------------------------------------------------------------------------
module speech_segment_tracker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sst_pkg::IDX_W-1:0]  cfg_index,
	input  logic [sst_pkg::DATA_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic [sst_pkg::PROB_W-1:0] win_prob,
	input  logic [sst_pkg::CNT_W-1:0]  audio_length,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [sst_pkg::CNT_W-1:0]  segment_start,
	output logic [sst_pkg::CNT_W-1:0]  segment_end
);

	sst_pkg::cfg_t cfg;
	sst_pkg::seg_t res, out_data;
	logic          accept, res_valid, full;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	sst_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sst_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (accept),
		.req_type     (req_type),
		.win_prob     (win_prob),
		.audio_length (audio_length),
		.res_valid    (res_valid),
		.res          (res)
	);

	sst_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

	assign segment_start = out_data.seg_start;
	assign segment_end   = out_data.seg_end;

endmodule
